FILE: src/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// shared constants and codes of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DataWidthDefault = 16;
   localparam int FracBitsDefault  = 8;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK  = 2'd0,
      STAT_SAT = 2'd1,
      STAT_DBZ = 2'd2,
      STAT_RSV = 2'd3
   } status_type;

endpackage

FILE: src/cau_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_divider
// pipelined restoring divider, BitsPerStage quotient bits per stage, with a
// saturation flag for quotients above the data range
// ----------------------------------------------------------------------------
module cau_divider import cau_pkg::*; #(
   parameter int NumWidth = 33,
   parameter int DenWidth = 32,
   parameter int QuoWidth = 24,
   parameter int BitsPerStage = 4,
   parameter int SideWidth = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 in_valid,
   input  logic [NumWidth-1:0]  in_num,
   input  logic [DenWidth-1:0]  in_den,
   input  logic [SideWidth-1:0] in_side,
   output logic                 out_valid,
   output logic [QuoWidth-1:0]  out_quo,
   output logic                 out_big,
   output logic [SideWidth-1:0] out_side
);

   localparam int Stages = (QuoWidth + BitsPerStage - 1) / BitsPerStage;
   localparam int RemWidth = DenWidth + 1;
   localparam int ShWidth = Stages * BitsPerStage;
   localparam int ExtWidth = NumWidth + ShWidth;

   logic [ExtWidth-1:0]  num_ext;
   logic                 big_in;

   logic                 vld_ff  [1:Stages];
   logic                 big_ff  [1:Stages];
   logic [ShWidth-1:0]   num_ff  [1:Stages];
   logic [RemWidth-1:0]  rem_ff  [1:Stages];
   logic [DenWidth-1:0]  den_ff  [1:Stages];
   logic [ShWidth-1:0]   quo_ff  [1:Stages];
   logic [SideWidth-1:0] side_ff [1:Stages];

   // upper numerator bits seed the remainder; a seed not below the
   // divisor means the quotient does not fit
   assign num_ext = ExtWidth'(in_num);
   assign big_in  = (num_ext >> ShWidth) >= ExtWidth'(in_den);

   // quotient bits are formed msb first over the low numerator bits
   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic                 src_vld, src_big;
      logic [ShWidth-1:0]   src_num, src_quo;
      logic [RemWidth-1:0]  src_rem;
      logic [DenWidth-1:0]  src_den;
      logic [SideWidth-1:0] src_side;
      logic [RemWidth-1:0]  rem_in;
      logic [ShWidth-1:0]   num_in;
      logic [ShWidth-1:0]   quo_in;
      logic [RemWidth:0]    trial;

      if (s == 0) begin : g_head
         assign src_vld  = in_valid;
         assign src_big  = big_in;
         assign src_num  = num_ext[ShWidth-1:0];
         assign src_rem  = RemWidth'(num_ext >> ShWidth);
         assign src_den  = in_den;
         assign src_quo  = '0;
         assign src_side = in_side;
      end else begin : g_tail
         assign src_vld  = vld_ff[s];
         assign src_big  = big_ff[s];
         assign src_num  = num_ff[s];
         assign src_rem  = rem_ff[s];
         assign src_den  = den_ff[s];
         assign src_quo  = quo_ff[s];
         assign src_side = side_ff[s];
      end

      always_comb begin
         rem_in = src_rem;
         num_in = src_num;
         quo_in = src_quo;
         trial  = '0;
         for (int k = 0; k < BitsPerStage; k++) begin
            trial = {rem_in, num_in[ShWidth-1]};
            num_in = {num_in[ShWidth-2:0], 1'b0};
            quo_in = {quo_in[ShWidth-2:0], 1'b0};
            if (trial >= {2'b0, src_den}) begin
               trial = trial - {2'b0, src_den};
               quo_in[0] = 1'b1;
            end
            rem_in = trial[RemWidth-1:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (enable) begin
            vld_ff[s+1] <= src_vld;
         end
         if (enable) begin
            big_ff[s+1]  <= src_big;
            num_ff[s+1]  <= num_in;
            rem_ff[s+1]  <= rem_in;
            den_ff[s+1]  <= src_den;
            quo_ff[s+1]  <= quo_in;
            side_ff[s+1] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[Stages];
   assign out_quo   = quo_ff[Stages][QuoWidth-1:0];
   assign out_big   = big_ff[Stages] || ((ShWidth > QuoWidth) ?
                      |(quo_ff[Stages] >> QuoWidth) : 1'b0);
   assign out_side  = side_ff[Stages];

endmodule

FILE: src/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// add, subtract, multiply or divide two signed fixed point complex numbers
// ----------------------------------------------------------------------------
// requests come in on the req_ stream: func in tuser, the four operand parts
// in tdata. each request gives one response on the rsp_ stream with the
// saturated real and imaginary parts and a status code.
// the pipeline takes one request every cycle while the receiver does not
// stall. it has three stages of capture, products and sums, then the
// divider with one stage per four quotient bits (7 stages at the default
// widths), then one stage of saturation. all four operations travel the
// same path so responses stay in order.
// when the receiver stalls, the whole pipeline holds; a response that is
// ready but not taken stays in the output register, and req_tready stays
// high as long as the output register is free or is being emptied.
// reset clears all valid bits; no request is lost or repeated.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int DATA_WIDTH = DataWidthDefault,
   parameter int FRAC_BITS  = FracBitsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // a_re, a_im, b_re, b_im
   input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   // func
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // res_re, res_im, status, zero fill
   output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0]   rsp_tdata
);

   localparam int W   = DATA_WIDTH;
   localparam int PW  = 2 * W;          // one product magnitude
   localparam int SW  = 2 * W + 1;      // sum of two products
   localparam int QW  = W + 1 + FRAC_BITS + 1;   // quotient bits kept
   localparam int NW  = SW + FRAC_BITS;
   localparam int OutW = ((2*W+2+7)/8)*8;
   localparam logic [SW-1:0] MaxMag = SW'({1'b0, {(W-1){1'b1}}});

   logic enable;
   logic out_vld_ff;
   assign enable = !out_vld_ff || rsp_tready;
   assign req_tready = enable;

   // ---------------- stage 1: capture
   logic               v1_ff;
   func_type           f1_ff;
   logic signed [W-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (enable) v1_ff <= req_tvalid;
      if (enable) begin
         f1_ff  <= func_type'(req_tuser);
         ar1_ff <= req_tdata[W-1:0];
         ai1_ff <= req_tdata[2*W-1:W];
         br1_ff <= req_tdata[3*W-1:2*W];
         bi1_ff <= req_tdata[4*W-1:3*W];
      end
   end

   // ---------------- stage 2: four products, divisor squares, sums and differences
   logic                v2_ff;
   func_type            f2_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic [PW-1:0]        d_r_ff, d_i_ff;
   logic signed [W:0]    sum_re2_ff, sum_im2_ff;
   logic                 bz2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (enable) v2_ff <= v1_ff;
      if (enable) begin
         f2_ff   <= f1_ff;
         p_rr_ff <= ar1_ff * br1_ff;
         p_ii_ff <= ai1_ff * bi1_ff;
         p_ri_ff <= ar1_ff * bi1_ff;
         p_ir_ff <= ai1_ff * br1_ff;
         d_r_ff  <= PW'(br1_ff) * PW'(br1_ff);
         d_i_ff  <= PW'(bi1_ff) * PW'(bi1_ff);
         bz2_ff  <= (br1_ff == '0) && (bi1_ff == '0);
         if (f1_ff == FUNC_SUB) begin
            sum_re2_ff <= {ar1_ff[W-1], ar1_ff} - {br1_ff[W-1], br1_ff};
            sum_im2_ff <= {ai1_ff[W-1], ai1_ff} - {bi1_ff[W-1], bi1_ff};
         end else begin
            sum_re2_ff <= {ar1_ff[W-1], ar1_ff} + {br1_ff[W-1], br1_ff};
            sum_im2_ff <= {ai1_ff[W-1], ai1_ff} + {bi1_ff[W-1], bi1_ff};
         end
      end
   end

   // ---------------- stage 3: combine products, take magnitudes
   logic                v3_ff;
   func_type            f3_ff;
   logic                bz3_ff;
   logic                neg_re3_ff, neg_im3_ff;
   logic [SW-1:0]       mag_re3_ff, mag_im3_ff;
   logic [SW-1:0]       den3_ff;
   logic signed [SW-1:0] t_re, t_im;

   always_comb begin
      case (f2_ff)
         FUNC_MUL: begin
            t_re = SW'(p_rr_ff) - SW'(p_ii_ff);
            t_im = SW'(p_ri_ff) + SW'(p_ir_ff);
         end
         FUNC_DIV: begin
            t_re = SW'(p_rr_ff) + SW'(p_ii_ff);
            t_im = SW'(p_ir_ff) - SW'(p_ri_ff);
         end
         default: begin
            t_re = SW'(sum_re2_ff);
            t_im = SW'(sum_im2_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (enable) v3_ff <= v2_ff;
      if (enable) begin
         f3_ff      <= f2_ff;
         bz3_ff     <= bz2_ff;
         neg_re3_ff <= t_re[SW-1];
         neg_im3_ff <= t_im[SW-1];
         mag_re3_ff <= t_re[SW-1] ? -t_re : t_re;
         mag_im3_ff <= t_im[SW-1] ? -t_im : t_im;
         den3_ff    <= SW'(d_r_ff) + SW'(d_i_ff);
      end
   end

   // ---------------- divider lanes; other operations ride along in side bits
   localparam int SideW = 2 + 1 + 1 + 1 + SW;
   logic [SideW-1:0] side_re_in, side_im_in, side_re_out, side_im_out;
   logic [SW-1:0]    den_safe;
   logic             dv_re, dv_im, big_re, big_im;
   logic [QW-1:0]    q_re, q_im;

   assign den_safe   = bz3_ff ? SW'(1) : den3_ff;
   assign side_re_in = {f3_ff, bz3_ff, neg_re3_ff, neg_im3_ff, mag_re3_ff};
   assign side_im_in = {f3_ff, bz3_ff, neg_re3_ff, neg_im3_ff, mag_im3_ff};

   cau_divider #(
      .NumWidth(NW), .DenWidth(SW), .QuoWidth(QW), .BitsPerStage(4), .SideWidth(SideW)
   ) u_div_re (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(v3_ff), .in_num({mag_re3_ff, {FRAC_BITS{1'b0}}}) , .in_den(den_safe),
      .in_side(side_re_in),
      .out_valid(dv_re), .out_quo(q_re), .out_big(big_re), .out_side(side_re_out)
   );

   cau_divider #(
      .NumWidth(NW), .DenWidth(SW), .QuoWidth(QW), .BitsPerStage(4), .SideWidth(SideW)
   ) u_div_im (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(v3_ff), .in_num({mag_im3_ff, {FRAC_BITS{1'b0}}}), .in_den(den_safe),
      .in_side(side_im_in),
      .out_valid(dv_im), .out_quo(q_im), .out_big(big_im), .out_side(side_im_out)
   );

   // ---------------- output stage: saturate and pack
   func_type      fo;
   logic          bzo, nre, nim;
   logic [SW-1:0] mre, mim;
   logic [SW-1:0] ure, uim;
   logic          hre, him;
   logic [W-1:0]  rre, rim;
   logic          sre, sim;
   status_type    st;
   logic [W-1:0]  out_re_ff, out_im_ff;
   status_type    out_st_ff;

   function automatic logic [W:0] sat_fn(input logic neg, input logic [SW-1:0] mag,
                                         input logic huge);
      logic [W-1:0] v;
      logic         s;
      begin
         s = 1'b0;
         if (!neg) begin
            if (huge || mag > MaxMag) begin
               v = {1'b0, {(W-1){1'b1}}}; s = 1'b1;
            end else begin
               v = mag[W-1:0];
            end
         end else begin
            if (huge || mag > MaxMag + SW'(1)) begin
               v = {1'b1, {(W-1){1'b0}}}; s = 1'b1;
            end else begin
               v = W'(-mag);
            end
         end
         sat_fn = {s, v};
      end
   endfunction

   always_comb begin
      fo  = func_type'(side_re_out[SideW-1 -: 2]);
      bzo = side_re_out[SW+2];
      nre = side_re_out[SW+1];
      nim = side_re_out[SW];
      mre = side_re_out[SW-1:0];
      mim = side_im_out[SW-1:0];
      if (fo == FUNC_DIV) begin
         ure = (QW >= SW) ? SW'(q_re) : SW'(q_re);
         uim = SW'(q_im);
         hre = big_re || ((QW > SW) ? |(q_re >> SW) : 1'b0);
         him = big_im || ((QW > SW) ? |(q_im >> SW) : 1'b0);
      end else if (fo == FUNC_MUL) begin
         ure = mre >> FRAC_BITS;
         uim = mim >> FRAC_BITS;
         hre = 1'b0;
         him = 1'b0;
      end else begin
         ure = mre;
         uim = mim;
         hre = 1'b0;
         him = 1'b0;
      end
      {sre, rre} = sat_fn(nre, ure, hre);
      {sim, rim} = sat_fn(nim, uim, him);
      if (fo == FUNC_DIV && bzo) begin
         rre = '0;
         rim = '0;
         st  = STAT_DBZ;
      end else if (sre || sim) begin
         st = STAT_SAT;
      end else begin
         st = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (enable) out_vld_ff <= dv_re && dv_im;
      if (enable) begin
         out_re_ff <= rre;
         out_im_ff <= rim;
         out_st_ff <= st;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OutW'({out_st_ff, out_im_ff, out_re_ff});

endmodule

FILE: test/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// checks sums, differences, products and quotients of the complex unit
// ----------------------------------------------------------------------------
// requests are queued by a stimulus block and driven in random bursts; each
// response is compared with a predicted result computed in rectangular form
// with truncation toward zero and saturation. the receiver stalls on its own
// pattern and holds off once for a long stretch so the pipeline fills up.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit import cau_pkg::*; ();

   localparam int DW = 16;
   localparam int FB = 8;
   localparam int REQ_W = ((4*DW+7)/8)*8;
   localparam int RSP_W = ((2*DW+2+7)/8)*8;
   localparam int LIMIT = 400000;
   localparam longint MAXV = 32767;
   localparam longint MINV = -32768;

   // field order matches {req_tuser, req_tdata}
   typedef struct packed {
      func_type        func;
      logic [DW-1:0]   b_im, b_re, a_im, a_re;
   } calc_req_type;

   typedef struct packed {
      logic [DW-1:0]   res_re, res_im;
      status_type      status;
   } calc_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   calc_req_type pending_reqs[$];
   calc_rsp_type expected_rsps[$];
   bit stimulus_done = 0;
   int mismatches = 0;
   int cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int holdoff = 0;
   bit holdoff_done = 0;

   complex_arithmetic_unit dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // saturate a value and flag it
   function automatic logic [DW-1:0] clamp(input longint v, inout bit sat);
      if (v > MAXV) begin
         sat = 1;
         return MAXV[DW-1:0];
      end
      if (v < MINV) begin
         sat = 1;
         return MINV[DW-1:0];
      end
      return v[DW-1:0];
   endfunction

   // truncated fixed point quotient, sign applied after division
   function automatic longint fx_quot(input longint n, input longint d);
      longint mag;
      mag = ((n < 0) ? -n : n);
      if (mag / d > (64'sd1 << DW)) mag = 64'sd1 << 40;
      else mag = (mag << FB) / d;
      return (n < 0) ? -mag : mag;
   endfunction

   function automatic longint fx_trunc(input longint p);
      return (p < 0) ? -((-p) >>> FB) : (p >>> FB);
   endfunction

   function automatic calc_rsp_type complex_result(input calc_req_type r);
      calc_rsp_type o;
      longint ar, ai, br, bi, d;
      bit sat;
      ar = longint'($signed(r.a_re));
      ai = longint'($signed(r.a_im));
      br = longint'($signed(r.b_re));
      bi = longint'($signed(r.b_im));
      sat = 0;
      o.status = STAT_OK;
      case (r.func)
         FUNC_ADD: begin
            o.res_re = clamp(ar + br, sat);
            o.res_im = clamp(ai + bi, sat);
         end
         FUNC_SUB: begin
            o.res_re = clamp(ar - br, sat);
            o.res_im = clamp(ai - bi, sat);
         end
         FUNC_MUL: begin
            o.res_re = clamp(fx_trunc(ar*br - ai*bi), sat);
            o.res_im = clamp(fx_trunc(ar*bi + ai*br), sat);
         end
         default: begin
            if (br == 0 && bi == 0) begin
               o.res_re = '0;
               o.res_im = '0;
               o.status = STAT_DBZ;
            end else begin
               d = br*br + bi*bi;
               o.res_re = clamp(fx_quot(ar*br + ai*bi, d), sat);
               o.res_im = clamp(fx_quot(ai*br - ar*bi, d), sat);
            end
         end
      endcase
      if (o.status == STAT_OK && sat) o.status = STAT_SAT;
      return o;
   endfunction

   function automatic logic [DW-1:0] pick_part();
      case ($urandom_range(0, 7))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return '0;
         3: return 16'(int'($urandom_range(0, 1023)) - 512);
         4: return 16'(int'($urandom_range(0, 16383)) - 8192);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_req(input func_type f, input logic [DW-1:0] ar, ai, br, bi);
      calc_req_type r;
      r.func = f;
      r.a_re = ar;
      r.a_im = ai;
      r.b_re = br;
      r.b_im = bi;
      pending_reqs.push_back(r);
   endtask

   initial begin
      queue_req(FUNC_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
      queue_req(FUNC_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0040);
      queue_req(FUNC_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
      queue_req(FUNC_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
      queue_req(FUNC_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
      queue_req(FUNC_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      queue_req(FUNC_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
      queue_req(FUNC_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001);
      queue_req(FUNC_MUL, 16'hfe80, 16'h0100, 16'h0200, 16'hff00);
      queue_req(FUNC_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
      queue_req(FUNC_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      queue_req(FUNC_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000);
      queue_req(FUNC_DIV, 16'hff00, 16'h0200, 16'hfe00, 16'hff00);
      queue_req(FUNC_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
      queue_req(FUNC_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
      queue_req(FUNC_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000);
      queue_req(FUNC_DIV, 16'h0300, 16'h0000, 16'h0000, 16'hff00);
      repeat (1100) begin
         queue_req(func_type'($urandom_range(0, 3)), pick_part(), pick_part(),
                   pick_part(), pick_part());
      end
      stimulus_done = 1;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid)
               expected_rsps.push_back(complex_result(calc_req_type'({req_tuser, req_tdata})));
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 0;
            end else if (pending_reqs.size() > 0) begin
               calc_req_type r;
               r = pending_reqs.pop_front();
               req_tvalid <= 1;
               req_tuser <= r.func;
               req_tdata <= {r.b_im, r.b_re, r.a_im, r.a_re};
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // receiver stall pattern with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (holdoff > 0) begin
         holdoff <= holdoff - 1;
         rsp_tready <= (holdoff == 1);
      end else if (!holdoff_done && expected_rsps.size() > 5 && cycles > 300) begin
         holdoff_done <= 1;
         holdoff <= 200;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ((cycles / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         calc_rsp_type got, want;
         got.res_re = rsp_tdata[DW-1:0];
         got.res_im = rsp_tdata[2*DW-1:DW];
         got.status = status_type'(rsp_tdata[2*DW+1:2*DW]);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = expected_rsps.pop_front();
            if (got.res_re !== want.res_re || got.res_im !== want.res_im ||
                got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected re %h im %h st %0d, got re %h im %h st %0d",
                           want.res_re, want.res_im, want.status,
                           got.res_re, got.res_im, got.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("tb_complex_arithmetic_unit: errors");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      wait (stimulus_done);
      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("tb_complex_arithmetic_unit: clean");
      else
         $display("tb_complex_arithmetic_unit: errors");
      $finish;
   end

endmodule
